>>> rtl/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg: shared types and constants for the indexed shift array
// Holds the array geometry, request and status codes, the beat payload
// structs and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package isa_pkg;

   // array geometry
   localparam int CAPACITY   = 64;
   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = (COUNT_BITS > 7) ? COUNT_BITS : 7;

   // read select tree: groups of cells, one group register per group
   localparam int SEL_BITS = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int LO_BITS  = (SEL_BITS + 1) / 2;
   localparam int GRP_BITS = (SEL_BITS - LO_BITS > 0) ? (SEL_BITS - LO_BITS) : 1;
   localparam int GSIZE    = 2 ** LO_BITS;
   localparam int NGROUP   = 2 ** GRP_BITS;

   // request codes
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_WRITE  = 3'd3;
   localparam logic [2:0] OP_INSERT = 3'd4;
   localparam logic [2:0] OP_ERASE  = 3'd5;
   localparam logic [2:0] OP_CLEAR  = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [6:0]  index;
      logic [31:0] value;
   } isa_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [6:0]  count;
   } isa_rsp_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic load_rsp;
   } isa_cmd_type;

endpackage

>>> rtl/isa_datapath.sv
// ----------------------------------------------------------------------------
// isa_datapath: element cells, count and read tree
// A row of cells that shift up on insert and down on erase, the element
// count, a two-level registered read select and the result register.
// ----------------------------------------------------------------------------
module isa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  isa_pkg::isa_cmd_type cmd,
   input  isa_pkg::isa_req_type req_data,
   output isa_pkg::isa_rsp_type rsp_data
);
   import isa_pkg::*;

   isa_req_type            req_ff;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [WORD_BITS-1:0]   cell_ff [CAPACITY];
   logic [WORD_BITS-1:0]   cell_in [CAPACITY];
   logic [WORD_BITS-1:0]   tap [NGROUP][GSIZE];
   logic [WORD_BITS-1:0]   grp_ff [NGROUP];
   logic [WORD_BITS-1:0]   grp_in [NGROUP];
   logic [1:0]             status_ff, status_in;
   logic                   rd_ok_ff, rd_ok_in;
   isa_rsp_type            rsp_ff;

   logic [CMP_BITS-1:0]    idx_w, n_w;
   logic [WORD_BITS-1:0]   word;
   logic [LO_BITS-1:0]     lo_sel;
   logic [GRP_BITS-1:0]    grp_sel;
   logic                   full, in_range;
   logic                   do_push, do_write, do_insert, do_erase;

   assign idx_w    = CMP_BITS'(req_ff.index);
   assign n_w      = CMP_BITS'(count_ff);
   assign word     = req_ff.value[WORD_BITS-1:0];
   assign full     = (count_ff == COUNT_BITS'(CAPACITY));
   assign in_range = (idx_w < n_w);
   assign lo_sel   = idx_w[LO_BITS-1:0];
   assign grp_sel  = idx_w[LO_BITS +: GRP_BITS];

   // decode the held request against the count
   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      rd_ok_in  = 1'b0;
      do_push   = 1'b0;
      do_write  = 1'b0;
      do_insert = 1'b0;
      do_erase  = 1'b0;
      case (req_ff.req_type)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               do_push  = 1'b1;
               count_in = COUNT_BITS'(count_ff + 1'b1);
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = COUNT_BITS'(count_ff - 1'b1);
            end
         end
         OP_READ: begin
            if (!in_range) status_in = ST_RANGE;
            else rd_ok_in = 1'b1;
         end
         OP_WRITE: begin
            if (!in_range) status_in = ST_RANGE;
            else do_write = 1'b1;
         end
         OP_INSERT: begin
            if (idx_w > n_w) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = COUNT_BITS'(count_ff + 1'b1);
            end
         end
         OP_ERASE: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end else begin
               do_erase = 1'b1;
               count_in = COUNT_BITS'(count_ff - 1'b1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // per-cell next value: load, shift up from below or shift down from above
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [CMP_BITS-1:0]  pos;
      logic [WORD_BITS-1:0] from_below, from_above;

      assign pos = CMP_BITS'(i);

      if (i > 0) begin : g_below
         assign from_below = cell_ff[i-1];
      end else begin : g_nobelow
         assign from_below = cell_ff[i];
      end

      if (i < CAPACITY - 1) begin : g_above
         assign from_above = cell_ff[i+1];
      end else begin : g_noabove
         assign from_above = cell_ff[i];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (do_push && pos == n_w) begin
            cell_in[i] = word;
         end else if (do_write && pos == idx_w) begin
            cell_in[i] = word;
         end else if (do_insert && pos == idx_w) begin
            cell_in[i] = word;
         end else if (do_insert && pos > idx_w) begin
            cell_in[i] = from_below;
         end else if (do_erase && pos >= idx_w) begin
            cell_in[i] = from_above;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.eval) cell_ff[i] <= cell_in[i];
      end
   end

   // first read level: one word per group, zero past the capacity
   for (genvar g = 0; g < NGROUP; g++) begin : g_grp
      for (genvar l = 0; l < GSIZE; l++) begin : g_tap
         if (g * GSIZE + l < CAPACITY) begin : g_live
            assign tap[g][l] = cell_ff[g * GSIZE + l];
         end else begin : g_pad
            assign tap[g][l] = '0;
         end
      end
      assign grp_in[g] = tap[g][lo_sel];
   end

   // hold the request on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.eval) begin
         count_ff <= count_in;
      end
   end

   // latch status and the group words during evaluation
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
         grp_ff    <= grp_in;
      end
   end

   // second read level into the result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.read_value <= rd_ok_ff ? 32'(grp_ff[grp_sel]) : 32'd0;
         rsp_ff.count      <= 7'(count_ff);
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("element count past capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.eval |=> $stable(count_ff))
      else $error("count changed outside evaluation");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && req_ff.req_type == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear left a nonzero count");
`endif

endmodule

>>> rtl/isa_ctrl.sv
// ----------------------------------------------------------------------------
// isa_ctrl: request sequencer
// Accepts one request beat, steps the datapath through evaluation and
// result load, and owns the result valid flag.
// ----------------------------------------------------------------------------
module isa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output isa_pkg::isa_cmd_type cmd
);
   import isa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // next state, commands and result valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EVAL))
      else $error("accepted beat did not start evaluation");

   a_eval_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |=> (state_ff == S_DONE))
      else $error("evaluation did not advance to result load");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result valid rose outside result load");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result overwrote a pending beat");
`endif

endmodule

>>> rtl/indexed_shift_array.sv
// After evaluation the result is loaded and rsp_valid raised once the result slot is free.
// A new request is accepted only once the previous one has gone through evaluate and load.
// Insert and erase shift every later cell in the evaluate state.
// A waiting result does not block the next accept; only its load waits.
// Reset clears the element count and control state; stored words stay undefined.
// ----------------------------------------------------------------------------
// indexed_shift_array: fixed-capacity ordered word array
// Push, pop, read, write, insert, erase and clear on a row of shift cells,
// one result beat per request beat.
// ----------------------------------------------------------------------------
module indexed_shift_array (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  isa_pkg::isa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output isa_pkg::isa_rsp_type rsp_data
);
   import isa_pkg::*;

   isa_cmd_type cmd;

   // sequencer
   isa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // cells, count and read path
   isa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> tb/indexed_shift_array_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_array_tb: self-checking bench for the indexed shift array
// Drives directed and random push, pop, read, write, insert, erase and clear
// beats with random idling on both sides, mirrors the array contents in a
// scoreboard and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module indexed_shift_array_tb;
   import isa_pkg::*;

   // request code that the block must ignore
   localparam logic [2:0]  OP_UNUSED = 3'd7;
   localparam logic [31:0] WORD_MASK = (WORD_BITS >= 32) ? 32'hFFFF_FFFF
                                                         : ((32'd1 << WORD_BITS) - 32'd1);
   localparam int          HOLD_CYCLES = 80;
   localparam int          PHASE_BEATS = 150;

   typedef enum logic [1:0] {GROW, CHURN, SHRINK} traffic_mode_type;

   // mirror of the array: predicts each result and checks the returned beats
   class shift_array_mirror;
      logic [31:0] words [CAPACITY];
      int unsigned fill;
      int unsigned peak_fill;
      isa_rsp_type owed [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned status_hits [4];

      function new();
         fill       = 0;
         peak_fill  = 0;
         mismatches = 0;
         checked    = 0;
         foreach (words[i]) words[i] = '0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      // apply one accepted request beat and queue its result
      function void note_request(isa_req_type beat);
         isa_rsp_type exp;
         int unsigned n;
         int unsigned idx;
         int          i;
         logic [31:0] val;
         n   = fill;
         idx = beat.index;
         val = beat.value & WORD_MASK;
         exp.status     = ST_OK;
         exp.read_value = '0;
         case (beat.req_type)
            OP_PUSH: begin
               if (n >= CAPACITY) exp.status = ST_FULL;
               else begin
                  words[n] = val;
                  fill     = n + 1;
               end
            end
            OP_POP: begin
               if (n == 0) exp.status = ST_EMPTY;
               else fill = n - 1;
            end
            OP_READ: begin
               if (idx >= n) exp.status = ST_RANGE;
               else exp.read_value = words[idx];
            end
            OP_WRITE: begin
               if (idx >= n) exp.status = ST_RANGE;
               else words[idx] = val;
            end
            OP_INSERT: begin
               // index check first, then the full check
               if (idx > n) exp.status = ST_RANGE;
               else if (n >= CAPACITY) exp.status = ST_FULL;
               else begin
                  for (i = n; i > int'(idx); i--) words[i] = words[i - 1];
                  words[idx] = val;
                  fill       = n + 1;
               end
            end
            OP_ERASE: begin
               if (idx >= n) exp.status = ST_RANGE;
               else begin
                  for (i = idx; i + 1 < int'(n); i++) words[i] = words[i + 1];
                  fill = n - 1;
               end
            end
            OP_CLEAR: fill = 0;
            default: ;
         endcase
         exp.count = 7'(fill);
         if (fill > peak_fill) peak_fill = fill;
         status_hits[exp.status]++;
         owed = {owed, exp};
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
         if (got !== exp) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, got);
            mismatches++;
         end
      endfunction

      // compare a result beat against the oldest prediction
      function void check_result(isa_rsp_type got);
         isa_rsp_type exp;
         if (owed.size() == 0) begin
            $display("%0t: result beat with no request waiting: status %0d read_value %h count %0d",
                     $time, got.status, got.read_value, got.count);
            mismatches++;
            return;
         end
         exp = owed.pop_front();
         checked++;
         compare_field("status", 32'(exp.status), 32'(got.status));
         compare_field("read_value", exp.read_value, got.read_value);
         compare_field("count", 32'(exp.count), 32'(got.count));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   isa_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   isa_rsp_type rsp_data;

   shift_array_mirror mirror;
   int unsigned       req_idle_pct = 9;
   int unsigned       rsp_idle_pct = 9;
   bit                hold_request = 1'b0;
   int unsigned       accepted = 0;

   indexed_shift_array dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request beat and hold it until accepted
   task automatic send_request(input logic [2:0] op, input logic [6:0] idx,
                               input logic [31:0] val);
      isa_req_type beat;
      beat.req_type = op;
      beat.index    = idx;
      beat.value    = val;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_request(beat);
      accepted++;
   endtask

   // pick an operation weighted by traffic mode
   function automatic logic [2:0] pick_op(traffic_mode_type mode);
      int unsigned roll;
      roll = $urandom_range(99);
      case (mode)
         GROW: begin
            if (roll < 35) return OP_PUSH;
            if (roll < 68) return OP_INSERT;
            if (roll < 80) return OP_WRITE;
            if (roll < 92) return OP_READ;
            if (roll < 95) return OP_ERASE;
            if (roll < 98) return OP_POP;
            return OP_UNUSED;
         end
         SHRINK: begin
            if (roll < 30) return OP_POP;
            if (roll < 60) return OP_ERASE;
            if (roll < 75) return OP_READ;
            if (roll < 85) return OP_WRITE;
            if (roll < 90) return OP_PUSH;
            if (roll < 95) return OP_INSERT;
            if (roll < 97) return OP_CLEAR;
            return OP_UNUSED;
         end
         default: begin
            if (roll < 15) return OP_PUSH;
            if (roll < 30) return OP_POP;
            if (roll < 50) return OP_READ;
            if (roll < 65) return OP_WRITE;
            if (roll < 80) return OP_INSERT;
            if (roll < 95) return OP_ERASE;
            if (roll < 97) return OP_CLEAR;
            return OP_UNUSED;
         end
      endcase
   endfunction

   // random beat: indexes mostly inside the valid range, some at its edges
   task automatic send_random(input traffic_mode_type mode);
      logic [2:0]  op;
      logic [6:0]  idx;
      logic [31:0] val;
      int unsigned n;
      int unsigned roll;
      n    = mirror.fill;
      op   = pick_op(mode);
      roll = $urandom_range(99);
      if (roll < 75)      idx = 7'($urandom_range(0, (n > 0) ? n - 1 : 0));
      else if (roll < 85) idx = 7'(n);
      else if (roll < 92) idx = 7'((n > 0) ? n - 1 : 0);
      else                idx = 7'($urandom_range(0, 127));
      roll = $urandom_range(99);
      if (roll < 5)       val = '0;
      else if (roll < 10) val = '1;
      else                val = $urandom;
      send_request(op, idx, val);
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mirror.check_result(rsp_data);
   end

   initial begin
      int               phase;
      int               drain;
      traffic_mode_type mode;
      mirror    = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-array errors, boundaries, shifts, clear, unused code
      send_request(OP_POP,    7'd0,   32'h0);
      send_request(OP_READ,   7'd0,   32'h0);
      send_request(OP_WRITE,  7'd0,   32'h1111_1111);
      send_request(OP_ERASE,  7'd0,   32'h0);
      send_request(OP_INSERT, 7'd1,   32'h2222_2222);
      send_request(OP_INSERT, 7'd0,   32'hFFFF_FFFF);
      send_request(OP_PUSH,   7'd0,   32'h0000_0000);
      send_request(OP_PUSH,   7'd127, 32'hA5A5_A5A5);
      send_request(OP_READ,   7'd0,   32'h0);
      send_request(OP_READ,   7'd2,   32'h0);
      send_request(OP_READ,   7'd3,   32'h0);
      send_request(OP_WRITE,  7'd1,   32'h5A5A_5A5A);
      send_request(OP_INSERT, 7'd1,   32'h1234_5678);
      send_request(OP_INSERT, 7'd4,   32'h8000_0001);
      send_request(OP_INSERT, 7'd6,   32'h3333_3333);
      send_request(OP_READ,   7'd1,   32'h0);
      send_request(OP_ERASE,  7'd0,   32'h0);
      send_request(OP_ERASE,  7'd3,   32'h0);
      send_request(OP_READ,   7'd127, 32'hFFFF_FFFF);
      send_request(OP_WRITE,  7'd64,  32'hFFFF_FFFF);
      send_request(OP_UNUSED, 7'd127, 32'hFFFF_FFFF);
      send_request(OP_READ,   7'd0,   32'h0);
      send_request(OP_CLEAR,  7'd0,   32'h0);
      send_request(OP_POP,    7'd0,   32'h0);
      send_request(OP_PUSH,   7'd0,   32'h0000_0007);
      send_request(OP_READ,   7'd0,   32'h0);

      // random phases: grow to full, churn, shrink to empty, twice over
      for (phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0:       mode = GROW;
            1:       mode = CHURN;
            default: mode = SHRINK;
         endcase
         req_idle_pct = (phase == 3) ? 0 : 9;
         rsp_idle_pct = (phase == 3) ? 0 : 9;
         if (phase == 1) hold_request = 1'b1;
         // pause the sender until every result is back
         if (phase == 3) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (mirror.owed.size() != 0) @(posedge clock);
         end
         repeat (PHASE_BEATS) send_random(mode);
      end

      // drain and let the pipeline settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.owed.size() != 0) @(posedge clock);
      for (drain = 0; drain < 20; drain++) @(posedge clock);

      $display("Ran %0d request beats, %0d results checked; peak fill %0d of %0d.",
               accepted, mirror.checked, mirror.peak_fill, CAPACITY);
      $display("Status mix: %0d ok, %0d out of range, %0d full, %0d empty pop.",
               mirror.status_hits[ST_OK], mirror.status_hits[ST_RANGE],
               mirror.status_hits[ST_FULL], mirror.status_hits[ST_EMPTY]);
      if (mirror.mismatches == 0 && mirror.owed.size() == 0) begin
         $display("** indexed_shift_array: PASSED **");
      end else begin
         $display("** indexed_shift_array: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("%0t: timeout with %0d results outstanding", $time, mirror.owed.size());
      $display("** indexed_shift_array: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
rtl/isa_pkg.sv
rtl/isa_datapath.sv
rtl/isa_ctrl.sv
rtl/indexed_shift_array.sv
tb/indexed_shift_array_tb.sv
